>>> rtl/dda_pkg.sv
package dda_pkg;

  // Default tile and fraction sizes.
  localparam int unsigned CoordBitsDef = 6;
  localparam int unsigned FracBitsDef  = 16;

  // Depth of the queue between the front and back parts.
  localparam int unsigned QueueDepthDef = 2;

  // Width of every coordinate field on the ports.
  localparam int unsigned FieldW = 6;

  // One line segment.
  typedef struct packed {
    logic [FieldW-1:0] x_start;
    logic [FieldW-1:0] y_start;
    logic [FieldW-1:0] x_end;
    logic [FieldW-1:0] y_end;
  } line_t;

  // One emitted pixel.
  typedef struct packed {
    logic [FieldW-1:0] pixel_x;
    logic [FieldW-1:0] pixel_y;
    logic              last_pixel;
  } pixel_t;

endpackage

>>> rtl/dda_queue.sv
module dda_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push;
  logic             pop;

  // Handshake and occupancy.
  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer wrap and count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/dda_front.sv
module dda_front #(
  parameter int unsigned COORD_BITS = dda_pkg::CoordBitsDef,
  parameter int unsigned FRAC_BITS  = dda_pkg::FracBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  dda_pkg::line_t                       in_data_i,
  output logic                                 push_valid_o,
  input  logic                                 push_ready_i,
  output logic [3*COORD_BITS+FRAC_BITS+3:0]    push_data_o
);

  import dda_pkg::*;

  localparam int unsigned C    = COORD_BITS;
  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned QuoW = C + F;
  localparam int unsigned CntW = $clog2(C + F);

  // Line descriptor handed to the back part.
  typedef struct packed {
    logic               x_major;
    logic               maj_neg;
    logic [C-1:0]       steps;
    logic [C-1:0]       maj_start;
    logic [C-1:0]       min_start;
    logic signed [F+1:0] inc;
  } desc_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUSH
  } state_e;

  state_e         state_q, state_d;
  logic           x_major_q, maj_neg_q, min_neg_q;
  logic [C-1:0]   steps_q, maj_start_q, min_start_q;
  logic [C-1:0]   rem_q;
  logic [QuoW-1:0] quo_q;
  logic [CntW-1:0] cnt_q;

  logic           accept;
  logic [C-1:0]   xs, ys, xe, ye;
  logic [C:0]     dx, dy;
  logic [C-1:0]   adx, ady;
  logic           x_major;
  logic [C-1:0]   min_abs;
  logic [C:0]     trial;
  logic           qbit;
  logic [C-1:0]   rem_next;
  logic [F+1:0]   mag;
  desc_t          desc;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);

  // Classify the incoming segment: deltas, major axis and directions.
  assign xs      = in_data_i.x_start[C-1:0];
  assign ys      = in_data_i.y_start[C-1:0];
  assign xe      = in_data_i.x_end[C-1:0];
  assign ye      = in_data_i.y_end[C-1:0];
  assign dx      = {1'b0, xe} - {1'b0, xs};
  assign dy      = {1'b0, ye} - {1'b0, ys};
  assign adx     = dx[C] ? C'(-dx) : dx[C-1:0];
  assign ady     = dy[C] ? C'(-dy) : dy[C-1:0];
  assign x_major = (adx >= ady);
  assign min_abs = x_major ? ady : adx;

  // One restoring division step: |minor delta| * 2^F / steps, one bit a cycle.
  assign trial    = {rem_q, quo_q[QuoW-1]};
  assign qbit     = (trial >= {1'b0, steps_q});
  assign rem_next = qbit ? C'(trial - {1'b0, steps_q}) : trial[C-1:0];

  // Signed increment rounded toward minus infinity.
  always_comb begin
    mag = {1'b0, quo_q[F:0]};
    if (min_neg_q && (rem_q != '0)) begin
      mag = mag + 1'b1;
    end
    desc.x_major   = x_major_q;
    desc.maj_neg   = maj_neg_q;
    desc.steps     = steps_q;
    desc.maj_start = maj_start_q;
    desc.min_start = min_start_q;
    desc.inc       = min_neg_q ? -$signed(mag) : $signed(mag);
  end

  assign push_valid_o = (state_q == ST_PUSH);
  assign push_data_o  = desc;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (x_major ? (adx == '0) : (ady == '0)) ? ST_PUSH : ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_q == CntW'(C + F - 1)) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (push_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Descriptor and divider registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_major_q   <= x_major;
      maj_neg_q   <= x_major ? dx[C] : dy[C];
      min_neg_q   <= x_major ? dy[C] : dx[C];
      steps_q     <= x_major ? adx : ady;
      maj_start_q <= x_major ? xs : ys;
      min_start_q <= x_major ? ys : xs;
      rem_q       <= '0;
      quo_q       <= {min_abs, {F{1'b0}}};
      cnt_q       <= '0;
    end else if (state_q == ST_DIV) begin
      rem_q <= rem_next;
      quo_q <= {quo_q[QuoW-2:0], qbit};
      cnt_q <= cnt_q + 1'b1;
    end
  end

endmodule

>>> rtl/dda_back.sv
module dda_back #(
  parameter int unsigned COORD_BITS = dda_pkg::CoordBitsDef,
  parameter int unsigned FRAC_BITS  = dda_pkg::FracBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              pop_valid_i,
  output logic                              pop_ready_o,
  input  logic [3*COORD_BITS+FRAC_BITS+3:0] pop_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output dda_pkg::pixel_t                   out_data_o
);

  import dda_pkg::*;

  localparam int unsigned C    = COORD_BITS;
  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned AccW = C + F;

  // Same layout as the front part produces.
  typedef struct packed {
    logic               x_major;
    logic               maj_neg;
    logic [C-1:0]       steps;
    logic [C-1:0]       maj_start;
    logic [C-1:0]       min_start;
    logic signed [F+1:0] inc;
  } desc_t;

  desc_t          desc_in;
  logic           busy_q;
  logic           out_valid_q;
  pixel_t         out_q;
  logic           x_major_q, maj_neg_q;
  logic [C-1:0]   steps_q, maj_q, k_q;
  logic [AccW-1:0] acc_q;
  logic signed [F+1:0] inc_q;

  logic           load;
  logic           emit;
  logic           last;
  logic [C-1:0]   mnr;
  pixel_t         pix;

  assign desc_in     = pop_data_i;
  assign pop_ready_o = !busy_q;
  assign load        = pop_valid_i && !busy_q;
  assign emit        = busy_q && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Current pixel from the major counter and the accumulator integer part.
  assign last = (k_q == steps_q);
  assign mnr  = acc_q[AccW-1:F];
  always_comb begin
    pix.pixel_x    = FieldW'(x_major_q ? maj_q : mnr);
    pix.pixel_y    = FieldW'(x_major_q ? mnr : maj_q);
    pix.last_pixel = last;
  end

  // Control flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
      end else if (emit && last) begin
        busy_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Stepping datapath and output register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      x_major_q <= desc_in.x_major;
      maj_neg_q <= desc_in.maj_neg;
      steps_q   <= desc_in.steps;
      maj_q     <= desc_in.maj_start;
      acc_q     <= {desc_in.min_start, 1'b1, {(F-1){1'b0}}};
      inc_q     <= desc_in.inc;
      k_q       <= '0;
    end else if (emit) begin
      maj_q <= maj_neg_q ? maj_q - 1'b1 : maj_q + 1'b1;
      acc_q <= acc_q + AccW'(inc_q);
      k_q   <= k_q + 1'b1;
    end
    if (emit) begin
      out_q <= pix;
    end
  end

endmodule

>>> rtl/dda_line_rasterizer_unit.sv
// DDA line rasterizer. Each input item is one segment inside a square tile of
// 2^COORD_BITS pixels on a side; the block emits every pixel from the start
// point to the end point, both included, one result item per pixel, with
// last_pixel set on the final one. A line whose longer axis spans n steps
// gives n+1 pixels at one per cycle while the receiver is ready, once it has
// been loaded into the stepper. The minor-axis increment is found by a
// one-bit-per-cycle divider in the front part, between accepting a line and
// handing it over; a two-entry queue lets that division run while the
// previous line is still being stepped, so long lines stream at the output
// rate and very short lines are paced by the divider.
module dda_line_rasterizer_unit #(
  parameter int unsigned COORD_BITS  = dda_pkg::CoordBitsDef,
  parameter int unsigned FRAC_BITS   = dda_pkg::FracBitsDef,
  parameter int unsigned QUEUE_DEPTH = dda_pkg::QueueDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  dda_pkg::line_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output dda_pkg::pixel_t out_data_o
);

  import dda_pkg::*;

  localparam int unsigned DescW = 3 * COORD_BITS + FRAC_BITS + 4;

  logic             push_valid, push_ready;
  logic [DescW-1:0] push_data;
  logic             pop_valid, pop_ready;
  logic [DescW-1:0] pop_data;

  // Segment classification and increment division.
  dda_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Descriptor queue between the two parts.
  dda_queue #(
    .WIDTH (DescW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Pixel stepper.
  dda_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dda_pkg::*;

  localparam int unsigned FracBits   = FracBitsDef;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned DrainWait  = 100;
  localparam int unsigned RandomLinesPerPhase = 75;

  logic   clk_i       = 1'b0;
  logic   rst_ni      = 1'b0;
  logic   in_valid_i  = 1'b0;
  logic   in_ready_o;
  line_t  in_data_i   = '0;
  logic   out_valid_o;
  logic   out_ready_i = 1'b0;
  pixel_t out_data_o;

  // Pixels still owed by the block, oldest first.
  pixel_t expected_pixels [$];
  pixel_t want_px;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // Percent chance per cycle that the sender holds back or the receiver stalls.
  int unsigned line_gap_pct    = 0;
  int unsigned pixel_stall_pct = 0;

  dda_line_rasterizer_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Walk one segment with the DDA and queue every pixel it covers.
  function automatic void predict_line_pixels(input line_t ln);
    int     xs, ys, xe, ye, dx, dy, adx, ady, steps;
    int     maj_start, maj_dir, min_start, min_delta, k;
    bit     x_major;
    longint acc, inc, num;
    logic [FieldW-1:0] maj, mnr;
    pixel_t px;
    xs = ln.x_start;
    ys = ln.y_start;
    xe = ln.x_end;
    ye = ln.y_end;
    dx = xe - xs;
    dy = ye - ys;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    x_major = (adx >= ady);
    steps = x_major ? adx : ady;
    maj_start = x_major ? xs : ys;
    maj_dir = ((x_major ? dx : dy) < 0) ? -1 : 1;
    min_start = x_major ? ys : xs;
    min_delta = x_major ? dy : dx;
    acc = (longint'(min_start) <<< FracBits) + (longint'(1) <<< (FracBits - 1));
    inc = 0;
    if (steps > 0) begin
      // Division must round toward minus infinity, not toward zero.
      num = longint'(min_delta) <<< FracBits;
      inc = num / steps;
      if ((num % steps) != 0 && num < 0) begin
        inc = inc - 1;
      end
    end
    for (k = 0; k <= steps; k++) begin
      maj = FieldW'(maj_start + maj_dir * k);
      mnr = (acc < 0) ? '0 : FieldW'(acc >>> FracBits);
      px.pixel_x    = x_major ? maj : mnr;
      px.pixel_y    = x_major ? mnr : maj;
      px.last_pixel = (k == steps);
      expected_pixels.push_back(px);
      acc = acc + inc;
    end
  endfunction

  // Offer one segment after an optional random gap and wait for it to be taken.
  task automatic send_line(input line_t ln);
    while ($urandom_range(99) < line_gap_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= ln;
    do @(posedge clk_i); while (!in_ready_o);
    predict_line_pixels(ln);
  endtask

  function automatic logic [FieldW-1:0] clamp_coord(input int c);
    if (c < 0) begin
      return '0;
    end
    if (c > 63) begin
      return 6'd63;
    end
    return FieldW'(c);
  endfunction

  // Mix of segment shapes: points, short strokes, axis and diagonal lines,
  // and fully random endpoints.
  function automatic line_t random_line();
    line_t ln;
    int unsigned pick, len;
    ln.x_start = FieldW'($urandom);
    ln.y_start = FieldW'($urandom);
    ln.x_end   = FieldW'($urandom);
    ln.y_end   = FieldW'($urandom);
    pick = $urandom_range(99);
    if (pick < 10) begin
      ln.x_end = ln.x_start;
      ln.y_end = ln.y_start;
    end else if (pick < 35) begin
      ln.x_end = clamp_coord(int'(ln.x_start) + int'($urandom_range(8)) - 4);
      ln.y_end = clamp_coord(int'(ln.y_start) + int'($urandom_range(8)) - 4);
    end else if (pick < 45) begin
      len = $urandom_range(63);
      case ($urandom_range(2))
        0: ln.y_end = ln.y_start;
        1: ln.x_end = ln.x_start;
        default: begin
          ln.x_end = clamp_coord(int'(ln.x_start) + int'(len));
          ln.y_end = clamp_coord(int'(ln.y_start) + int'(len));
        end
      endcase
    end
    return ln;
  endfunction

  // Tile corners, all x-major octants and two y-major ones, zero length and one-pixel minor slopes.
  task automatic test_directed_lines();
    line_t directed_set [22] = '{
      '{6'd0,  6'd0,  6'd0,  6'd0},
      '{6'd63, 6'd63, 6'd63, 6'd63},
      '{6'd0,  6'd0,  6'd63, 6'd63},
      '{6'd63, 6'd63, 6'd0,  6'd0},
      '{6'd63, 6'd0,  6'd0,  6'd63},
      '{6'd0,  6'd63, 6'd63, 6'd0},
      '{6'd0,  6'd0,  6'd63, 6'd0},
      '{6'd0,  6'd0,  6'd0,  6'd63},
      '{6'd63, 6'd63, 6'd0,  6'd63},
      '{6'd63, 6'd63, 6'd63, 6'd0},
      '{6'd10, 6'd10, 6'd50, 6'd20},
      '{6'd50, 6'd20, 6'd10, 6'd10},
      '{6'd10, 6'd10, 6'd20, 6'd50},
      '{6'd20, 6'd50, 6'd10, 6'd10},
      '{6'd10, 6'd50, 6'd50, 6'd40},
      '{6'd40, 6'd10, 6'd50, 6'd50},
      '{6'd0,  6'd0,  6'd63, 6'd1},
      '{6'd0,  6'd0,  6'd1,  6'd63},
      '{6'd63, 6'd0,  6'd0,  6'd1},
      '{6'd1,  6'd63, 6'd0,  6'd0},
      '{6'd32, 6'd32, 6'd33, 6'd32},
      '{6'd5,  6'd5,  6'd6,  6'd7}
    };
    line_gap_pct    = 0;
    pixel_stall_pct = 0;
    foreach (directed_set[i]) begin
      send_line(directed_set[i]);
    end
  endtask

  task automatic run_random_lines(input int unsigned gap_pct, input int unsigned stall_pct);
    line_gap_pct    = gap_pct;
    pixel_stall_pct = stall_pct;
    repeat (RandomLinesPerPhase) begin
      send_line(random_line());
    end
  endtask

  task automatic test_no_idle();
    run_random_lines(0, 0);
  endtask

  task automatic test_sender_idle();
    run_random_lines(88, 0);
  endtask

  task automatic test_receiver_stall();
    run_random_lines(0, 88);
  endtask

  task automatic test_both_idle();
    run_random_lines(18, 18);
  endtask

  // The receiver drops ready at random according to the current phase.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= pixel_stall_pct);
  end

  // Compare every accepted pixel with the oldest one still owed.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel x=%0d y=%0d last_pixel=%0d",
               out_data_o.pixel_x, out_data_o.pixel_y, out_data_o.last_pixel);
        mismatch_count++;
      end else begin
        want_px = expected_pixels.pop_front();
        if (out_data_o.pixel_x !== want_px.pixel_x) begin
          $error("pixel_x expected %0d actual %0d", want_px.pixel_x, out_data_o.pixel_x);
          mismatch_count++;
        end
        if (out_data_o.pixel_y !== want_px.pixel_y) begin
          $error("pixel_y expected %0d actual %0d", want_px.pixel_y, out_data_o.pixel_y);
          mismatch_count++;
        end
        if (out_data_o.last_pixel !== want_px.last_pixel) begin
          $error("last_pixel expected %0d actual %0d",
                 want_px.last_pixel, out_data_o.last_pixel);
          mismatch_count++;
        end
      end
    end
  end

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("dda_line_rasterizer_unit test failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_lines();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Let the block finish, then watch a while for stray pixels.
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("dda_line_rasterizer_unit test passed");
    end else begin
      $display("dda_line_rasterizer_unit test failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/dda_pkg.sv
rtl/dda_queue.sv
rtl/dda_front.sv
rtl/dda_back.sv
rtl/dda_line_rasterizer_unit.sv
bench/tb_top.sv
